[rtl/sqbp_pkg.sv]
// Package: shared constants, register indexes and types of the quantizer packer.
package sqbp_pkg;

  localparam int MAX_CODE_BITS  = 4;
  localparam int MAX_VECTOR_DIM = 4096;
  localparam int SAMPLE_WIDTH   = 16;

  localparam int WORD_W      = 64;
  localparam int FILL_W      = $clog2(WORD_W);
  localparam int CODE_W      = MAX_CODE_BITS;
  localparam int BITS_W      = 3;
  localparam int DIM_W       = 13;
  localparam int COORD_W     = 12;
  localparam int IDX_W       = 8;
  localparam int BOUND_W     = 16;
  localparam int NUM_BOUNDS  = (1 << MAX_CODE_BITS) - 1;
  localparam int BOUNDS_PER_SET = WORD_W / BOUND_W;
  localparam int NUM_SETS    = 4;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_DIM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BSET_0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BSET_1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BSET_2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BSET_3     = 3'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef struct packed {
    logic [BITS_W-1:0]                   code_bits;
    logic [DIM_W-1:0]                    vector_dim;
    logic [NUM_SETS-1:0][WORD_W-1:0]     bset;
  } sqbp_cfg_t;

  // One queue entry: the words produced by one sample, at most two.
  typedef struct packed {
    logic [WORD_W-1:0] word0;
    logic [IDX_W-1:0]  idx0;
    logic              last0;
    logic              has_second;
    logic [WORD_W-1:0] word1;
    logic [IDX_W-1:0]  idx1;
  } sqbp_entry_t;

endpackage

[rtl/sqbp_if.sv]
// Interfaces: sample channel into the packer and packed word channel out of it.
interface sqbp_sample_if;
  import sqbp_pkg::*;
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sqbp_word_if;
  import sqbp_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_word;
  logic [IDX_W-1:0]  word_index;
  logic              last_word;

  modport source (output valid, output packed_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input packed_word, input word_index, input last_word,
                output ready);
endinterface

[rtl/scalar_quantize_bit_packer.sv]
// Top level: scalar quantizer with 64-bit code packing.
//
// Usage:
//   sample_i carries one signed Q1.15 coordinate per transaction. Each sample is
//   compared against the first 2^code_bits-1 boundaries and the resulting code
//   is appended LSB first into a 64-bit word; codes may straddle words.
//   word_o carries one packed word per transaction with its index inside the
//   vector and a last_word flag on the final word of each vector.
//   Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i
//   (0 code_bits, 1 vector_dim, 2..5 boundary sets) while the block is idle.
// Timing:
//   One sample per cycle is accepted while the queue is not full. A finished word
//   passes through the queue and the output register, which sends one word per
//   cycle when not stalled, so a two-word entry stays queued until both are sent.
// Stall and reset:
//   When word_o stalls, the four-entry queue absorbs words; sample_i.ready drops
//   only when that queue is full. Reset clears packer state, the queue and the
//   output register, and returns code_bits and vector_dim to 1, boundaries to 0.
module scalar_quantize_bit_packer import sqbp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sqbp_sample_if.sink           sample_i,
  sqbp_word_if.source           word_o
);

  sqbp_cfg_t   cfg_q, cfg_d;
  sqbp_entry_t q_entry;
  sqbp_entry_t q_head;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  // Register file: hold each value until its index is written.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CODE_BITS:  cfg_d.code_bits  = cfg_wdata_i[BITS_W-1:0];
        CFG_VECTOR_DIM: cfg_d.vector_dim = cfg_wdata_i[DIM_W-1:0];
        CFG_BSET_0:     cfg_d.bset[0]    = cfg_wdata_i;
        CFG_BSET_1:     cfg_d.bset[1]    = cfg_wdata_i;
        CFG_BSET_2:     cfg_d.bset[2]    = cfg_wdata_i;
        CFG_BSET_3:     cfg_d.bset[3]    = cfg_wdata_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_bits  <= BITS_W'(1);
      cfg_q.vector_dim <= DIM_W'(1);
      cfg_q.bset       <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: quantize and pack, push finished words.
  sqbp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_i),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_entry)
  );

  // Queue: decouple packing from output backpressure.
  sqbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: serialize entries onto the word channel.
  sqbp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (q_head),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .word_o  (word_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_word_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(word_o.valid) |-> $past(!q_empty))
    else $error("output word without a queued entry");
`endif

endmodule

[rtl/sqbp_front.sv]
// Front end: quantize each sample, pack the code and queue the finished words.
module sqbp_front import sqbp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  sqbp_sample_if.sink         sample_i,
  input  sqbp_cfg_t           cfg_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output sqbp_entry_t         q_entry_o
);

  logic [WORD_W-1:0]  partial_q, partial_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [COORD_W-1:0] coord_q, coord_d;
  logic [IDX_W-1:0]   wcnt_q, wcnt_d;

  logic [BITS_W-1:0]     bits;
  logic [DIM_W-1:0]      dim;
  logic [CODE_W:0]       nb;
  logic [NUM_BOUNDS-1:0] exceed;
  logic [NUM_BOUNDS-1:0] run;
  logic [CODE_W-1:0]     code;
  logic                  last;
  logic                  accept;
  logic [WORD_W-1:0]     word;
  logic [WORD_W-1:0]     rest;
  logic [FILL_W:0]       newfill;
  logic                  full;
  logic                  leftover;

  assign sample_i.ready = !q_full_i;
  assign accept = sample_i.valid && sample_i.ready;

  // Clamp the code width and vector length into their legal ranges.
  always_comb begin
    bits = cfg_i.code_bits;
    if (bits == '0) bits = BITS_W'(1);
    else if (bits > BITS_W'(MAX_CODE_BITS)) bits = BITS_W'(MAX_CODE_BITS);
    dim = cfg_i.vector_dim;
    if (dim == '0) dim = DIM_W'(1);
    else if (dim > DIM_W'(MAX_VECTOR_DIM)) dim = DIM_W'(MAX_VECTOR_DIM);
  end

  assign nb = (CODE_W+1)'(((CODE_W+1)'(1) << bits) - (CODE_W+1)'(1));

  for (genvar gi = 0; gi < NUM_BOUNDS; gi++) begin : g_cmp
    logic signed [BOUND_W-1:0] bound;
    assign bound = $signed(cfg_i.bset[gi / BOUNDS_PER_SET][(gi % BOUNDS_PER_SET) * BOUND_W +:
                                                           BOUND_W]);
    assign exceed[gi] = (sample_i.sample > bound) && ((CODE_W+1)'(gi) < nb);
  end

  // Walk stops at the first boundary not exceeded.
  always_comb begin
    run[0] = exceed[0];
    for (int i = 1; i < NUM_BOUNDS; i++) begin
      run[i] = run[i-1] & exceed[i];
    end
  end

  assign code = CODE_W'($countones(run));
  assign last = ({1'b0, coord_q} + DIM_W'(1)) >= dim;

  assign word     = partial_q | (WORD_W'(code) << fill_q);
  assign newfill  = {1'b0, fill_q} + (FILL_W+1)'(bits);
  assign full     = newfill[FILL_W];
  assign rest     = WORD_W'(code >> ((FILL_W+1)'(WORD_W) - {1'b0, fill_q}));
  assign leftover = last && (newfill[FILL_W-1:0] != '0);

  always_comb begin
    q_entry_o.word0      = word;
    q_entry_o.idx0       = wcnt_q;
    q_entry_o.last0      = full ? (last && !leftover) : 1'b1;
    q_entry_o.has_second = full && leftover;
    q_entry_o.word1      = rest;
    q_entry_o.idx1       = wcnt_q + IDX_W'(1);
  end

  assign q_push_o = accept && (full || leftover);

  always_comb begin
    partial_d = partial_q;
    fill_d    = fill_q;
    coord_d   = coord_q;
    wcnt_d    = wcnt_q;
    if (accept) begin
      if (last) begin
        partial_d = '0;
        fill_d    = '0;
        coord_d   = '0;
        wcnt_d    = '0;
      end else begin
        partial_d = full ? rest : word;
        fill_d    = newfill[FILL_W-1:0];
        coord_d   = coord_q + COORD_W'(1);
        wcnt_d    = full ? wcnt_q + IDX_W'(1) : wcnt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      fill_q    <= '0;
      coord_q   <= '0;
      wcnt_q    <= '0;
    end else begin
      partial_q <= partial_d;
      fill_q    <= fill_d;
      coord_q   <= coord_d;
      wcnt_q    <= wcnt_d;
    end
  end

endmodule

[rtl/sqbp_queue.sv]
// Queue: short register FIFO of word entries between front and back end.
module sqbp_queue import sqbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  sqbp_entry_t entry_i,
  input  logic        pop_i,
  output sqbp_entry_t head_o,
  output logic        full_o,
  output logic        empty_o
);

  sqbp_entry_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[rtl/sqbp_back.sv]
// Back end: split queue entries into single words and drive the output register.
module sqbp_back import sqbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sqbp_entry_t head_i,
  input  logic        empty_i,
  output logic        pop_o,
  sqbp_word_if.source word_o
);

  logic              out_vld_q, out_vld_d;
  logic              second_q, second_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              last_q, last_d;
  logic              load;

  assign load  = (!out_vld_q || word_o.ready) && !empty_i;
  assign pop_o = load && (second_q || !head_i.has_second);

  always_comb begin
    out_vld_d = out_vld_q;
    second_d  = second_q;
    word_d    = word_q;
    idx_d     = idx_q;
    last_d    = last_q;
    if (load) begin
      out_vld_d = 1'b1;
      if (second_q) begin
        word_d   = head_i.word1;
        idx_d    = head_i.idx1;
        last_d   = 1'b1;
        second_d = 1'b0;
      end else begin
        word_d   = head_i.word0;
        idx_d    = head_i.idx0;
        last_d   = head_i.last0;
        second_d = head_i.has_second;
      end
    end else if (word_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      second_q  <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      second_q  <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    idx_q  <= idx_d;
    last_q <= last_d;
  end

  assign word_o.valid       = out_vld_q;
  assign word_o.packed_word = word_q;
  assign word_o.word_index  = idx_q;
  assign word_o.last_word   = last_q;

endmodule

[bench/scalar_quantize_bit_packer_tb.sv]
// Testbench for the scalar quantizer bit packer: directed and random stimulus against a predictor.
`timescale 1ns / 1ps

module scalar_quantize_bit_packer_tb;
  import sqbp_pkg::*;

  localparam int unsigned HALF_PERIOD   = 5;
  localparam int unsigned CYCLE_LIMIT   = 600_000;
  // Words pass through the queue and the output register; allow a margin on top.
  localparam int unsigned SETTLE_CYCLES = 12;

  // One packed word as it should leave the block.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  index;
    logic              last_flag;
  } packed_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sqbp_sample_if smp ();
  sqbp_word_if   wrd ();

  scalar_quantize_bit_packer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (smp),
    .word_o      (wrd)
  );

  // Predictor copy of the configuration registers.
  logic [BITS_W-1:0] model_bits;
  logic [DIM_W-1:0]  model_dim;
  logic [WORD_W-1:0] model_bset [NUM_SETS];

  // Predictor copy of the packer state.
  logic [WORD_W-1:0]  acc_word;
  logic [FILL_W-1:0]  acc_fill;
  logic [COORD_W-1:0] coord_cnt;
  logic [IDX_W-1:0]   word_cnt;

  // Words predicted but not yet seen on the output, oldest first.
  packed_result_t pending_words [$];

  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic void push_result(input logic [WORD_W-1:0] w, input logic [IDX_W-1:0] idx,
                                      input logic last_flag);
    packed_result_t r;
    r.word      = w;
    r.index     = idx;
    r.last_flag = last_flag;
    pending_words.push_back(r);
  endfunction

  // Quantize one sample against the boundary table and append its code to the
  // packed word; queue every word that this sample completes.
  function automatic void quantize_and_pack(input logic signed [SAMPLE_WIDTH-1:0] s);
    int unsigned               nbits;
    int unsigned               dim;
    int unsigned               nbounds;
    int unsigned               newfill;
    int unsigned               i;
    logic [WORD_W-1:0]         code;
    logic [WORD_W-1:0]         rest;
    logic signed [BOUND_W-1:0] bnd;
    logic                      walking;
    logic                      at_last;
    nbits = model_bits;
    if (nbits < 1) nbits = 1;
    if (nbits > MAX_CODE_BITS) nbits = MAX_CODE_BITS;
    dim = model_dim;
    if (dim < 1) dim = 1;
    if (dim > MAX_VECTOR_DIM) dim = MAX_VECTOR_DIM;

    // Walk boundaries upward; stop at the first one not exceeded.
    nbounds = (1 << nbits) - 1;
    code    = '0;
    walking = 1'b1;
    for (i = 0; i < nbounds; i++) begin
      bnd = model_bset[i / BOUNDS_PER_SET][(i % BOUNDS_PER_SET) * BOUND_W +: BOUND_W];
      if (walking && s > bnd) code++;
      else walking = 1'b0;
    end

    at_last  = (coord_cnt + 1) >= dim;
    acc_word = acc_word | (code << acc_fill);
    newfill  = acc_fill + nbits;
    if (newfill >= WORD_W) begin
      // Carry the code bits that did not fit into the next word.
      rest    = (newfill > WORD_W) ? (code >> (WORD_W - acc_fill)) : '0;
      newfill = newfill - WORD_W;
      push_result(acc_word, word_cnt, at_last && newfill == 0);
      word_cnt = word_cnt + 1'b1;
      acc_word = rest;
    end
    acc_fill = FILL_W'(newfill);

    if (at_last) begin
      if (acc_fill != 0) push_result(acc_word, word_cnt, 1'b1);
      acc_word  = '0;
      acc_fill  = '0;
      coord_cnt = '0;
      word_cnt  = '0;
    end else begin
      coord_cnt = coord_cnt + 1'b1;
    end
  endfunction

  // Predict on each accepted sample transaction, then check each accepted
  // word transaction against the oldest prediction. Also guard the run length.
  always @(posedge clk_i) begin
    packed_result_t head;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni) begin
      if (smp.valid && smp.ready) quantize_and_pack(smp.sample);
      if (wrd.valid && wrd.ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: packed_word %h word_index %0d last_word %b",
                 wrd.packed_word, wrd.word_index, wrd.last_word);
          mismatches++;
        end else begin
          head = pending_words.pop_front();
          if (wrd.packed_word !== head.word) begin
            $error("packed_word: expected %h, got %h", head.word, wrd.packed_word);
            mismatches++;
          end
          if (wrd.word_index !== head.index) begin
            $error("word_index: expected %0d, got %0d", head.index, wrd.word_index);
            mismatches++;
          end
          if (wrd.last_word !== head.last_flag) begin
            $error("last_word: expected %b, got %b", head.last_flag, wrd.last_word);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver: stall at random, at the current stall rate.
  always @(negedge clk_i) begin
    wrd.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Write one register; the block must be idle. Mirror the write in the predictor.
  // Drop the enable after each write, keeping it low until the task returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CODE_BITS:  model_bits    = val[BITS_W-1:0];
      CFG_VECTOR_DIM: model_dim     = val[DIM_W-1:0];
      CFG_BSET_0:     model_bset[0] = val;
      CFG_BSET_1:     model_bset[1] = val;
      CFG_BSET_2:     model_bset[2] = val;
      CFG_BSET_3:     model_bset[3] = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Load all four boundary registers: a random ascending table, or random noise.
  task automatic program_boundaries(input bit ascending);
    logic [WORD_W-1:0] w [NUM_SETS];
    int                b;
    int                i;
    for (i = 0; i < NUM_SETS; i++) w[i] = {$urandom, $urandom};
    if (ascending) begin
      b = ($urandom_range(0, 3) == 0) ? -32768 : -32768 + int'($urandom_range(0, 6000));
      for (i = 0; i < NUM_BOUNDS; i++) begin
        w[i / BOUNDS_PER_SET][(i % BOUNDS_PER_SET) * BOUND_W +: BOUND_W] = b[BOUND_W-1:0];
        b = b + int'($urandom_range(0, 4500));
        if (b > 32767) b = 32767;
      end
    end
    write_reg(CFG_BSET_0, w[0]);
    write_reg(CFG_BSET_1, w[1]);
    write_reg(CFG_BSET_2, w[2]);
    write_reg(CFG_BSET_3, w[3]);
  endtask

  function automatic logic [WORD_W-1:0] pack_bounds(input int b0, input int b1, input int b2,
                                                    input int b3);
    return {b3[15:0], b2[15:0], b1[15:0], b0[15:0]};
  endfunction

  // Mix extremes, values at or beside a boundary, and uniform noise.
  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    int unsigned          i;
    logic [BOUND_W-1:0]   bnd;
    i   = $urandom_range(0, NUM_BOUNDS - 1);
    bnd = model_bset[i / BOUNDS_PER_SET][(i % BOUNDS_PER_SET) * BOUND_W +: BOUND_W];
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1, 2, 3: return bnd + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one sample and hold it until the block takes the transaction.
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      smp.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp.valid  <= 1'b1;
    smp.sample <= s;
    do @(posedge clk_i); while (!smp.ready);
    @(negedge clk_i);
  endtask

  task automatic send_burst(input int unsigned n);
    repeat (n) send_sample(pick_sample());
  endtask

  // Drop valid, drain every predicted word, then let the pipeline empty.
  task automatic settle();
    smp.valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Reset values: one-bit codes, one-coordinate vectors, all boundaries zero.
  task automatic test_reset_state();
    send_sample(16'sh8000);
    send_sample(16'shffff);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'sh7fff);
    settle();
  endtask

  // Out-of-range code width and vector length clamp to the legal range.
  task automatic test_clamps();
    int i;
    write_reg(CFG_CODE_BITS, 0);
    write_reg(CFG_VECTOR_DIM, 3);
    write_reg(CFG_BSET_0, pack_bounds(0, 0, 0, 0));
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0001);
    settle();
    write_reg(CFG_CODE_BITS, 7);
    for (i = 0; i < NUM_SETS; i++)
      write_reg(CFG_IDX_W'(CFG_BSET_0 + i),
                pack_bounds(-28000 + 16000 * i, -24000 + 16000 * i,
                            -20000 + 16000 * i, -16000 + 16000 * i));
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
    settle();
    write_reg(CFG_CODE_BITS, 5);
    write_reg(CFG_VECTOR_DIM, 0);
    send_sample(16'sh7fff);
    send_sample(16'sh1234);
    settle();
  endtask

  // A non-ascending table: the walk stops at the first boundary not exceeded.
  task automatic test_non_ascending();
    write_reg(CFG_CODE_BITS, MAX_CODE_BITS);
    write_reg(CFG_VECTOR_DIM, 1);
    write_reg(CFG_BSET_0, pack_bounds(0, 20000, -20000, -30000));
    write_reg(CFG_BSET_1, pack_bounds(-32768, -32768, -32768, -32768));
    write_reg(CFG_BSET_2, pack_bounds(-32768, -32768, -32768, -32768));
    write_reg(CFG_BSET_3, pack_bounds(-32768, -32768, -32768, 12345));
    send_sample(16'sd10000);
    send_sample(16'sd25000);
    send_sample(16'sh8000);
    settle();
  endtask

  // The word fills exactly on the last coordinate, then a code straddles the
  // word boundary on the last coordinate.
  task automatic test_fill_on_last();
    program_boundaries(1'b1);
    write_reg(CFG_CODE_BITS, 4);
    write_reg(CFG_VECTOR_DIM, 16);
    send_burst(16);
    settle();
    write_reg(CFG_CODE_BITS, 3);
    write_reg(CFG_VECTOR_DIM, 22);
    send_burst(22);
    settle();
  endtask

  // Shrink the vector length below the count already reached mid-vector.
  task automatic test_mid_vector_change();
    write_reg(CFG_CODE_BITS, 2);
    write_reg(CFG_VECTOR_DIM, 8);
    send_burst(5);
    settle();
    write_reg(CFG_CODE_BITS, 3);
    write_reg(CFG_VECTOR_DIM, 3);
    send_burst(1);
    settle();
  endtask

  // Widest codes with an oversized vector length: a run of full words builds
  // up and the open vector carries into the next test, which shortens it.
  task automatic test_longest_vector();
    program_boundaries(1'b1);
    write_reg(CFG_CODE_BITS, 7);
    write_reg(CFG_VECTOR_DIM, 13'h1fff);
    send_burst(256);
    settle();
  endtask

  // Random phases under one idling mix. Each phase reprograms every register;
  // vectors usually carry over from one phase into the next.
  task automatic test_random(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned dim;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (4) begin
      case ($urandom_range(0, 9))
        0:       dim = 0;
        1:       dim = $urandom_range(25, 300);
        default: dim = $urandom_range(1, 24);
      endcase
      write_reg(CFG_CODE_BITS, CFG_DATA_W'($urandom_range(0, 7)));
      write_reg(CFG_VECTOR_DIM, CFG_DATA_W'(dim));
      program_boundaries($urandom_range(0, 4) != 0);
      send_burst($urandom_range(20, 46));
      settle();
    end
  endtask

  initial begin
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    smp.valid  = 1'b0;
    smp.sample = '0;
    wrd.ready  = 1'b0;

    model_bits = 1;
    model_dim  = 1;
    for (int i = 0; i < NUM_SETS; i++) model_bset[i] = '0;
    acc_word  = '0;
    acc_fill  = '0;
    coord_cnt = '0;
    word_cnt  = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_clamps();
    test_non_ascending();
    test_fill_on_last();
    test_mid_vector_change();
    test_longest_vector();

    test_random(30, 77);
    test_random(77, 30);
    test_random(0, 0);

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
